FILE: hdl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and byte formatting for the UTF-16 to UTF-8 encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

    localparam int QDepth   = 2;
    localparam int QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCountW  = $clog2(QDepth + 1);

    localparam logic [5:0]  LeadTag     = 6'b110110;
    localparam logic [5:0]  TrailTag    = 6'b110111;
    localparam logic [20:0] SuppOffset  = 21'h10000;
    localparam logic [15:0] OneByteMax  = 16'h007F;
    localparam logic [15:0] TwoByteLim  = 16'h0800;
    localparam logic [7:0]  ContMark    = 8'h80;
    localparam logic [7:0]  Lead2Mark   = 8'hC0;
    localparam logic [7:0]  Lead3Mark   = 8'hE0;
    localparam logic [7:0]  Lead4Mark   = 8'hF0;

    typedef enum logic [1:0] {
        LEN_ONE   = 2'd0,
        LEN_TWO   = 2'd1,
        LEN_THREE = 2'd2,
        LEN_FOUR  = 2'd3
    } seq_len_t;

    typedef struct packed {
        logic [20:0] code_point;
        seq_len_t    len;
        logic        orphan;
    } char_rec_t;

    typedef struct packed {
        logic      push;
        char_rec_t rec;
    } q_write_t;

    typedef struct packed {
        logic      empty;
        char_rec_t rec;
    } q_head_t;

    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        return ContMark | {2'b00, bits};
    endfunction

    function automatic logic [7:0] utf8_byte(input char_rec_t rec, input logic [1:0] idx);
        logic [20:0] cp;
        logic [7:0]  b;
        cp = rec.code_point;
        b  = cont_byte(cp[5:0]);
        unique case (rec.len)
            LEN_ONE:
                b = cp[7:0];
            LEN_TWO:
                b = (idx == 2'd0) ? (Lead2Mark | {3'b000, cp[10:6]}) : cont_byte(cp[5:0]);
            LEN_THREE:
                case (idx)
                    2'd0:    b = Lead3Mark | {4'b0000, cp[15:12]};
                    2'd1:    b = cont_byte(cp[11:6]);
                    default: b = cont_byte(cp[5:0]);
                endcase
            LEN_FOUR:
                case (idx)
                    2'd0:    b = Lead4Mark | {5'b00000, cp[20:18]};
                    2'd1:    b = cont_byte(cp[17:12]);
                    2'd2:    b = cont_byte(cp[11:6]);
                    default: b = cont_byte(cp[5:0]);
                endcase
            default:
                b = cont_byte(cp[5:0]);
        endcase
        return b;
    endfunction

endpackage

FILE: hdl/u16u8_if.sv
// ----------------------------------------------------------------------------
// u16u8 channel interfaces
// Valid/ready channels for UTF-16 code units and UTF-8 bytes.
// ----------------------------------------------------------------------------
interface u16u8_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;

    modport source (output valid, output code_unit, input ready);
    modport sink   (input valid, input code_unit, output ready);
endinterface

interface u16u8_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_char;
    logic       orphan_lead;

    modport source (output valid, output out_byte, output last_of_char,
                    output orphan_lead, input ready);
    modport sink   (input valid, input out_byte, input last_of_char,
                    input orphan_lead, output ready);
endinterface

FILE: hdl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates and builds one character record.
// ----------------------------------------------------------------------------
module u16u8_front (
    input  logic              clk,
    input  logic              rst_n,
    u16u8_unit_if.sink        units,
    input  logic              q_full,
    output u16u8_pkg::q_write_t q_wr
);
    import u16u8_pkg::*;

    logic [9:0] held_reg, held_next;
    logic       pending_reg, pending_next;
    logic       owed_reg, owed_next;

    logic        accept;
    logic        is_lead;
    logic        is_trail;
    logic        pair;
    logic [15:0] u;

    assign units.ready = !q_full;
    assign accept      = units.valid && units.ready;
    assign u           = units.code_unit;
    assign is_lead     = (u[15:10] == LeadTag);
    assign is_trail    = (u[15:10] == TrailTag);
    assign pair        = is_trail && pending_reg;

    always_comb
    begin
        q_wr.push = accept && !is_lead;
        if (pair)
        begin
            q_wr.rec.code_point = {1'b0, held_reg, u[9:0]} + SuppOffset;
            q_wr.rec.len        = LEN_FOUR;
            q_wr.rec.orphan     = owed_reg;
        end
        else
        begin
            q_wr.rec.code_point = {5'b00000, u};
            q_wr.rec.orphan     = owed_reg || pending_reg;
            if (u <= OneByteMax)
                q_wr.rec.len = LEN_ONE;
            else if (u < TwoByteLim)
                q_wr.rec.len = LEN_TWO;
            else
                q_wr.rec.len = LEN_THREE;
        end
    end

    always_comb
    begin
        held_next    = held_reg;
        pending_next = pending_reg;
        owed_next    = owed_reg;
        if (accept)
        begin
            if (is_lead)
            begin
                owed_next    = owed_reg || pending_reg;
                held_next    = u[9:0];
                pending_next = 1'b1;
            end
            else
            begin
                owed_next    = 1'b0;
                held_next    = '0;
                pending_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            pending_reg <= 1'b0;
            owed_reg    <= 1'b0;
        end
        else
        begin
            held_reg    <= held_next;
            pending_reg <= pending_next;
            owed_reg    <= owed_next;
        end
    end

endmodule

FILE: hdl/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// Short FIFO of character records between the front and back halves.
// ----------------------------------------------------------------------------
module u16u8_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  u16u8_pkg::q_write_t  q_wr,
    input  logic                 pop,
    output logic                 full,
    output u16u8_pkg::q_head_t   head
);
    import u16u8_pkg::*;

    char_rec_t           mem [QDepth];
    logic [QPtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCountW-1:0]  count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign full       = (count_reg == QCountW'(QDepth));
    assign head.empty = (count_reg == '0);
    assign head.rec   = mem[rd_ptr_reg];
    assign do_push    = q_wr.push && !full;
    assign do_pop     = pop && !head.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + QCountW'(do_push) - QCountW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= q_wr.rec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Serializes each character record into UTF-8 bytes through an output register.
// ----------------------------------------------------------------------------
module u16u8_back (
    input  logic                clk,
    input  logic                rst_n,
    input  u16u8_pkg::q_head_t  head,
    output logic                pop,
    u16u8_byte_if.source        bytes
);
    import u16u8_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       orphan_reg, orphan_next;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       emit;
    logic       at_last;

    assign load    = !valid_reg || bytes.ready;
    assign emit    = load && !head.empty;
    assign at_last = (idx_reg == head.rec.len);
    assign pop     = emit && at_last;

    always_comb
    begin
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        orphan_next = orphan_reg;
        idx_next    = idx_reg;
        if (load)
            valid_next = !head.empty;
        if (emit)
        begin
            byte_next   = utf8_byte(head.rec, idx_reg);
            last_next   = at_last;
            orphan_next = head.rec.orphan;
            idx_next    = at_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        orphan_reg <= orphan_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assign bytes.valid        = valid_reg;
    assign bytes.out_byte     = byte_reg;
    assign bytes.last_of_char = last_reg;
    assign bytes.orphan_lead  = orphan_reg;

endmodule

FILE: hdl/utf16_to_utf8_stream_encoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_stream_encoder
// Streams UTF-16 code units in and UTF-8 bytes out, pairing surrogates.
// ----------------------------------------------------------------------------
//  channel      dir   payload                                   handshake
//  code_units   in    code_unit[15:0]                           valid/ready
//  utf8_bytes   out   out_byte[7:0], last_of_char, orphan_lead  valid/ready
//
//  One output byte per cycle from the back serializer while the output is
//  ready and a record waits: a unit gives 1 to 3 bytes, a surrogate pair 4
//  bytes over its two units, a lead alone none. Units enter every cycle
//  while the two-entry record queue has room. rst_n clears surrogate state,
//  queue and output valid asynchronously. A stalled output holds its byte;
//  the front keeps taking units until the record queue is full, then drops
//  code_units.ready.
// ----------------------------------------------------------------------------
module utf16_to_utf8_stream_encoder (
    input  logic          clk,
    input  logic          rst_n,
    u16u8_unit_if.sink    code_units,
    u16u8_byte_if.source  utf8_bytes
);
    import u16u8_pkg::*;

    q_write_t q_wr;
    q_head_t  head;
    logic     q_full;
    logic     pop;

    u16u8_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .units  (code_units),
        .q_full (q_full),
        .q_wr   (q_wr)
    );

    u16u8_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    u16u8_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .bytes (utf8_bytes)
    );

endmodule

FILE: hdl/u16u8_checker.sv
// ----------------------------------------------------------------------------
// u16u8_checker
// Port-level checks on the encoder's byte stream, bound to the top level.
// ----------------------------------------------------------------------------
module u16u8_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       last_of_char,
    input logic       orphan_lead
);

    logic out_acc;
    assign out_acc = out_valid && out_ready;

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_byte) && $stable(last_of_char)
                                    && $stable(orphan_lead))
        else $error("output payload changed while stalled");

    a_ascii_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !out_byte[7] |-> last_of_char)
        else $error("single-byte character not marked last");

    a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && (out_byte[7:6] == 2'b11) |-> !last_of_char)
        else $error("sequence lead byte marked last");

    a_after_last_not_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && last_of_char ##1 out_acc |-> (out_byte[7:6] != 2'b10))
        else $error("continuation byte starts a character");

endmodule

bind utf16_to_utf8_stream_encoder u16u8_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (utf8_bytes.valid),
    .out_ready    (utf8_bytes.ready),
    .out_byte     (utf8_bytes.out_byte),
    .last_of_char (utf8_bytes.last_of_char),
    .orphan_lead  (utf8_bytes.orphan_lead)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams UTF-16 code units into the encoder and checks every UTF-8 byte,
// its end-of-character mark and its dropped-lead flag against an in-bench
// encoder, under random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    import u16u8_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       orphan;
    } utf8_byte_t;

    localparam logic [15:0] DIRECTED_UNITS [24] = '{
        16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF,
        16'hD7FF, 16'hE000, 16'hDC00, 16'hDFFF,
        16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF,
        16'hD800, 16'h0041,
        16'hD801, 16'hDBFF, 16'hDC01,
        16'hD800, 16'hDA00, 16'h07FF,
        16'hDB00, 16'hFFFE
    };

    logic clk = 1'b0;
    logic rst_n;

    u16u8_unit_if unit_ch ();
    u16u8_byte_if byte_ch ();

    utf16_to_utf8_stream_encoder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .code_units (unit_ch),
        .utf8_bytes (byte_ch)
    );

    logic [15:0] unit_queue [$];
    utf8_byte_t  utf8_expected [$];

    logic [9:0]  held_lead;
    logic        lead_held;
    logic        orphan_owed;

    int          sender_idle_pct;
    int          receiver_idle_pct;
    logic        hold_output;
    int          hold_mark;
    int          units_accepted;
    int          fail_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void push_utf8(input logic [7:0] data, input logic last,
                                      input logic orphan);
        utf8_byte_t b;
        b.data   = data;
        b.last   = last;
        b.orphan = orphan;
        utf8_expected.push_back(b);
    endfunction

    function automatic void predict_utf8(input logic [15:0] unit);
        logic [20:0] cp;
        logic        flag;
        if (unit[15:10] == LeadTag)
        begin
            if (lead_held)
                orphan_owed = 1'b1;
            held_lead = unit[9:0];
            lead_held = 1'b1;
        end
        else if (unit[15:10] == TrailTag && lead_held)
        begin
            cp = SuppOffset + {1'b0, held_lead, unit[9:0]};
            flag = orphan_owed;
            lead_held = 1'b0;
            held_lead = '0;
            orphan_owed = 1'b0;
            push_utf8(Lead4Mark | {5'b0, cp[20:18]}, 1'b0, flag);
            push_utf8(ContMark | {2'b0, cp[17:12]}, 1'b0, flag);
            push_utf8(ContMark | {2'b0, cp[11:6]}, 1'b0, flag);
            push_utf8(ContMark | {2'b0, cp[5:0]}, 1'b1, flag);
        end
        else
        begin
            flag = orphan_owed | lead_held;
            lead_held = 1'b0;
            held_lead = '0;
            orphan_owed = 1'b0;
            if (unit <= OneByteMax)
                push_utf8(unit[7:0], 1'b1, flag);
            else if (unit < TwoByteLim)
            begin
                push_utf8(Lead2Mark | {3'b0, unit[10:6]}, 1'b0, flag);
                push_utf8(ContMark | {2'b0, unit[5:0]}, 1'b1, flag);
            end
            else
            begin
                push_utf8(Lead3Mark | {4'b0, unit[15:12]}, 1'b0, flag);
                push_utf8(ContMark | {2'b0, unit[11:6]}, 1'b0, flag);
                push_utf8(ContMark | {2'b0, unit[5:0]}, 1'b1, flag);
            end
        end
    endfunction

    // mostly well-formed characters, some lone surrogates and raw noise
    function automatic int queue_random_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25)
            unit_queue.push_back(16'($urandom_range(16'h007F)));
        else if (pick < 45)
            unit_queue.push_back(16'($urandom_range(16'h07FF, 16'h0080)));
        else if (pick < 65)
        begin
            if ($urandom_range(1) == 0)
                unit_queue.push_back(16'($urandom_range(16'hD7FF, 16'h0800)));
            else
                unit_queue.push_back(16'($urandom_range(16'hFFFF, 16'hE000)));
        end
        else if (pick < 88)
        begin
            unit_queue.push_back(16'($urandom_range(16'hDBFF, 16'hD800)));
            unit_queue.push_back(16'($urandom_range(16'hDFFF, 16'hDC00)));
            return 2;
        end
        else if (pick < 92)
            unit_queue.push_back(16'($urandom_range(16'hDBFF, 16'hD800)));
        else if (pick < 96)
            unit_queue.push_back(16'($urandom_range(16'hDFFF, 16'hDC00)));
        else
            unit_queue.push_back(16'($urandom()));
        return 1;
    endfunction

    task automatic wait_drained();
        while (unit_queue.size() != 0 || unit_ch.valid || utf8_expected.size() != 0)
            @(negedge clk);
    endtask

    task automatic queue_random_units(input int count);
        int n;
        n = 0;
        while (n < count)
            n += queue_random_char();
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            unit_ch.valid <= 1'b0;
        else
        begin
            if (unit_ch.valid && unit_ch.ready)
            begin
                predict_utf8(unit_ch.code_unit);
                units_accepted <= units_accepted + 1;
            end
            if (!unit_ch.valid || unit_ch.ready)
            begin
                if (unit_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    unit_ch.valid     <= 1'b1;
                    unit_ch.code_unit <= unit_queue.pop_front();
                end
                else
                    unit_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            byte_ch.ready <= 1'b0;
        else
            byte_ch.ready <= !hold_output && ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        utf8_byte_t want;
        if (rst_n && byte_ch.valid && byte_ch.ready)
        begin
            if (utf8_expected.size() == 0)
            begin
                $error("unexpected transaction: out_byte actual %02h", byte_ch.out_byte);
                fail_count++;
            end
            else
            begin
                want = utf8_expected.pop_front();
                if (byte_ch.out_byte !== want.data)
                begin
                    $error("out_byte expected %02h actual %02h", want.data, byte_ch.out_byte);
                    fail_count++;
                end
                if (byte_ch.last_of_char !== want.last)
                begin
                    $error("last_of_char expected %0b actual %0b", want.last,
                           byte_ch.last_of_char);
                    fail_count++;
                end
                if (byte_ch.orphan_lead !== want.orphan)
                begin
                    $error("orphan_lead expected %0b actual %0b", want.orphan,
                           byte_ch.orphan_lead);
                    fail_count++;
                end
            end
        end
    end

    // hold the output long enough for the record queue to fill and stall the input
    initial
    begin
        while (hold_mark == 0 || units_accepted < hold_mark)
            @(negedge clk);
        hold_output = 1'b1;
        repeat (80) @(negedge clk);
        hold_output = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        unit_ch.valid     = 1'b0;
        unit_ch.code_unit = '0;
        byte_ch.ready     = 1'b0;
        held_lead         = '0;
        lead_held         = 1'b0;
        orphan_owed       = 1'b0;
        hold_output       = 1'b0;
        hold_mark         = 0;
        units_accepted    = 0;
        fail_count        = 0;
        sender_idle_pct   = 22;
        receiver_idle_pct = 74;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED_UNITS[i])
            unit_queue.push_back(DIRECTED_UNITS[i]);
        queue_random_units(150);
        wait_drained();

        sender_idle_pct   = 74;
        receiver_idle_pct = 22;
        queue_random_units(150);
        wait_drained();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_mark         = units_accepted + 30;
        queue_random_units(160);
        wait_drained();

        repeat (12) @(negedge clk);
        if (utf8_expected.size() != 0)
        begin
            $error("%0d expected transactions never arrived", utf8_expected.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/u16u8_pkg.sv
hdl/u16u8_if.sv
hdl/u16u8_front.sv
hdl/u16u8_queue.sv
hdl/u16u8_back.sv
hdl/utf16_to_utf8_stream_encoder.sv
hdl/u16u8_checker.sv
tb/sv/testbench.sv
